// ===== sv/csp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants for the call stack profiler.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int TABLE_DEPTH_DEF = 1024;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } csp_op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INACTIVE  = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_MISMATCH  = 3'd4,
    ST_FULL      = 3'd5,
    ST_HALTED    = 3'd6
  } csp_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_TOP,
    S_ELAP,
    S_SEARCH,
    S_EMIT
  } csp_state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] fn_addr;
    logic [63:0] site_addr;
    logic [63:0] timestamp;
    logic [31:0] overhead;
    logic [9:0]  read_index;
  } csp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] rec_fn;
    logic [63:0] rec_total;
    logic [31:0] rec_calls;
    logic [63:0] self_time;
    logic [10:0] record_count;
    logic [6:0]  stack_level;
  } csp_out_t;

  typedef struct packed {
    logic        latch;
    logic        clear;
    logic        rd_issue;
    logic        push;
    logic        top_issue;
    logic        top_calc;
    logic        elap_calc;
    logic        srch_step;
    logic        hit_upd;
    logic        insert;
    logic        pop;
    logic        set_halt;
    logic        set_st;
    csp_status_t st;
    logic        res_read;
    logic        res_zero;
    logic        emit;
  } csp_cmd_t;

  typedef struct packed {
    csp_op_t op;
    logic    halted;
    logic    active;
    logic    stk_full;
    logic    stk_empty;
    logic    idx_ok;
    logic    mismatch;
    logic    match;
    logic    srch_end;
    logic    tbl_full;
    logic    out_free;
  } csp_stat_t;

endpackage

// ===== sv/csp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_ctrl
// Event sequencer: decodes each transaction and steps the datapath.
// ----------------------------------------------------------------------------
module csp_ctrl import csp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  csp_stat_t stat,
  output csp_cmd_t  cmd
);

  csp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.st    = ST_OK;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_EMIT;
        cmd.set_st = 1'b1;
        cmd.res_zero = 1'b1;
        case (stat.op)
          OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          OP_READ: begin
            if (stat.idx_ok) begin
              cmd.set_st = 1'b0;
              cmd.res_zero = 1'b0;
              cmd.rd_issue = 1'b1;
              state_nxt = S_READ;
            end else begin
              cmd.st = ST_HALTED;
            end
          end
          default: begin
            if (stat.halted) begin
              cmd.st = ST_HALTED;
            end else if (!stat.active) begin
              cmd.st = ST_INACTIVE;
            end else if (stat.op == OP_ENTER) begin
              if (stat.stk_full) begin
                cmd.st = ST_OVERFLOW;
                cmd.set_halt = 1'b1;
              end else begin
                cmd.push = 1'b1;
              end
            end else if (stat.stk_empty) begin
              cmd.st = ST_UNDERFLOW;
              cmd.set_halt = 1'b1;
            end else begin
              cmd.set_st = 1'b0;
              cmd.res_zero = 1'b0;
              cmd.top_issue = 1'b1;
              state_nxt = S_TOP;
            end
          end
        endcase
      end
      S_READ: begin
        cmd.res_read = 1'b1;
        cmd.set_st = 1'b1;
        state_nxt = S_EMIT;
      end
      S_TOP: begin
        if (stat.mismatch) begin
          cmd.set_st = 1'b1;
          cmd.st = ST_MISMATCH;
          cmd.set_halt = 1'b1;
          cmd.res_zero = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.top_calc = 1'b1;
          state_nxt = S_ELAP;
        end
      end
      S_ELAP: begin
        cmd.elap_calc = 1'b1;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.match) begin
          cmd.hit_upd = 1'b1;
          cmd.pop = 1'b1;
          cmd.set_st = 1'b1;
          state_nxt = S_EMIT;
        end else if (stat.srch_end) begin
          cmd.set_st = 1'b1;
          state_nxt = S_EMIT;
          if (stat.tbl_full) begin
            cmd.st = ST_FULL;
            cmd.set_halt = 1'b1;
            cmd.res_zero = 1'b1;
          end else begin
            cmd.insert = 1'b1;
            cmd.pop = 1'b1;
          end
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/csp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_dp
// Datapath: frame stack, record table, charge accumulator, result register.
// ----------------------------------------------------------------------------
module csp_dp import csp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  csp_in_t   in_data,
  input  logic      cfg_valid,
  input  logic      cfg_data,
  input  csp_cmd_t  cmd,
  output csp_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output csp_out_t  out_data
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int TCW = $clog2(TABLE_DEPTH + 1);

  csp_in_t        in_r;
  logic           active_r, halted_r, out_valid_r, pend_r;
  logic [SCW-1:0] open_r;
  logic [TCW-1:0] used_r, sidx_r;
  logic [TAW-1:0] pidx_r;
  logic [63:0]    gchg_r, gnew;
  csp_status_t    st_r;
  csp_out_t       out_r;

  // frame stack; base holds the charge accumulator at push time
  logic [63:0] stk_fn_m    [STACK_DEPTH];
  logic [63:0] stk_site_m  [STACK_DEPTH];
  logic [63:0] stk_start_m [STACK_DEPTH];
  logic [63:0] stk_base_m  [STACK_DEPTH];
  logic [63:0] top_fn_r, top_site_r, top_start_r, top_base_r;
  logic [63:0] t1_r, ovf_r, elap_r;

  logic [63:0] rec_fn_m    [TABLE_DEPTH];
  logic [63:0] rec_tot_m   [TABLE_DEPTH];
  logic [31:0] rec_calls_m [TABLE_DEPTH];
  logic [63:0] rd_fn_r, rd_tot_r;
  logic [31:0] rd_calls_r;

  logic [63:0] res_fn_r, res_tot_r, res_self_r;
  logic [31:0] res_calls_r;

  logic [SAW-1:0] stk_wa, stk_ra;
  logic [TAW-1:0] rec_ra, rec_wa;
  logic           rec_re, rec_we;
  logic [63:0]    rec_wtot, new_tot;
  logic [31:0]    rec_wcalls, new_calls;
  logic [63:0]    rec_wfn;

  assign gnew    = gchg_r + 64'(in_r.overhead);
  assign stk_wa  = open_r[SAW-1:0];
  assign stk_ra  = SAW'(open_r - SCW'(1));
  assign new_tot = rd_tot_r + elap_r;
  assign new_calls = (rd_calls_r == '1) ? rd_calls_r : rd_calls_r + 32'd1;

  always_comb begin
    rec_re = cmd.rd_issue | cmd.srch_step;
    rec_ra = cmd.rd_issue ? TAW'(in_r.read_index) : sidx_r[TAW-1:0];
    rec_we = cmd.hit_upd | cmd.insert;
    if (cmd.hit_upd) begin
      rec_wa = pidx_r;
      rec_wfn = rd_fn_r;
      rec_wtot = new_tot;
      rec_wcalls = new_calls;
    end else begin
      rec_wa = used_r[TAW-1:0];
      rec_wfn = in_r.fn_addr;
      rec_wtot = elap_r;
      rec_wcalls = 32'd1;
    end
  end

  always_comb begin
    stat.op        = csp_op_t'(in_r.opcode);
    stat.halted    = halted_r;
    stat.active    = active_r;
    stat.stk_full  = (32'(open_r) >= 32'(STACK_DEPTH));
    stat.stk_empty = (open_r == '0);
    stat.idx_ok    = (32'(in_r.read_index) < 32'(used_r)) &&
                     (32'(in_r.read_index) < 32'(TABLE_DEPTH));
    stat.mismatch  = (top_fn_r != in_r.fn_addr) && (top_site_r != in_r.site_addr);
    stat.match     = pend_r && (rd_fn_r == in_r.fn_addr);
    stat.srch_end  = (sidx_r == used_r);
    stat.tbl_full  = (32'(used_r) >= 32'(TABLE_DEPTH));
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_fn_m[stk_wa]    <= in_r.fn_addr;
      stk_site_m[stk_wa]  <= in_r.site_addr;
      stk_start_m[stk_wa] <= in_r.timestamp;
      stk_base_m[stk_wa]  <= gnew;
    end
    if (cmd.top_issue) begin
      top_fn_r    <= stk_fn_m[stk_ra];
      top_site_r  <= stk_site_m[stk_ra];
      top_start_r <= stk_start_m[stk_ra];
      top_base_r  <= stk_base_m[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_fn_m[rec_wa]    <= rec_wfn;
      rec_tot_m[rec_wa]   <= rec_wtot;
      rec_calls_m[rec_wa] <= rec_wcalls;
    end
    if (rec_re) begin
      rd_fn_r    <= rec_fn_m[rec_ra];
      rd_tot_r   <= rec_tot_m[rec_ra];
      rd_calls_r <= rec_calls_m[rec_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r <= in_data;
    end
    if (cmd.top_calc) begin
      t1_r  <= in_r.timestamp - top_start_r;
      ovf_r <= gchg_r - top_base_r;
    end
    if (cmd.elap_calc) begin
      elap_r <= t1_r - ovf_r;
      sidx_r <= '0;
    end
    if (cmd.srch_step) begin
      sidx_r <= sidx_r + TCW'(1);
      pidx_r <= sidx_r[TAW-1:0];
    end
    if (cmd.set_st) begin
      st_r <= cmd.st;
    end
    if (cmd.res_zero) begin
      res_fn_r    <= '0;
      res_tot_r   <= '0;
      res_calls_r <= '0;
      res_self_r  <= '0;
    end else if (cmd.res_read) begin
      res_fn_r    <= rd_fn_r;
      res_tot_r   <= rd_tot_r;
      res_calls_r <= rd_calls_r;
      res_self_r  <= '0;
    end else if (cmd.hit_upd) begin
      res_fn_r    <= rd_fn_r;
      res_tot_r   <= new_tot;
      res_calls_r <= new_calls;
      res_self_r  <= elap_r;
    end else if (cmd.insert) begin
      res_fn_r    <= in_r.fn_addr;
      res_tot_r   <= elap_r;
      res_calls_r <= 32'd1;
      res_self_r  <= elap_r;
    end
    if (cmd.emit) begin
      out_r.status       <= st_r;
      out_r.rec_fn       <= res_fn_r;
      out_r.rec_total    <= res_tot_r;
      out_r.rec_calls    <= res_calls_r;
      out_r.self_time    <= res_self_r;
      out_r.record_count <= 11'(used_r);
      out_r.stack_level  <= 7'(open_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      halted_r    <= 1'b0;
      open_r      <= '0;
      used_r      <= '0;
      gchg_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_r <= cfg_data;
      end
      if (cmd.clear) begin
        halted_r <= 1'b0;
        used_r   <= '0;
      end else if (cmd.insert) begin
        used_r <= used_r + TCW'(1);
      end
      if (cmd.set_halt) begin
        halted_r <= 1'b1;
      end
      if (cmd.push) begin
        open_r <= open_r + SCW'(1);
        gchg_r <= gnew;
      end else if (cmd.pop) begin
        open_r <= open_r - SCW'(1);
        gchg_r <= gnew;
      end
      if (cmd.elap_calc) begin
        pend_r <= 1'b0;
      end else if (cmd.srch_step) begin
        pend_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/call_stack_profiler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_stack_profiler_core
// Function-level profiler: frame stack plus per-function record table.
// ----------------------------------------------------------------------------
// One transaction in gives one result out. Enter, clear, a bad read and the
// overflow and underflow errors go from dispatch straight to emit; a record
// read and a frame mismatch pass one more state first; an exit, and the
// table full error, run a linear search of the record table through its
// single read port, one entry per cycle. Overhead charged to outer frames
// is kept as one running sum, so enter and exit cost no walk of the stack.
// The configuration write is taken in any cycle.
module call_stack_profiler_core import csp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  csp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output csp_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  csp_cmd_t  cmd;
  csp_stat_t stat;

  assign cfg_ready = 1'b1;

  csp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csp_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
